>>> src/bcc_pkg.sv
// Package for the button click classifier: event codes, register indexes,
// reset values and the item and result structs. No dependencies.
`default_nettype none

package bcc_pkg;

    localparam int unsigned TICK_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        EV_IDLE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 1'b1;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd300;

    typedef struct packed {
        logic button_low;
        logic ack_click;
        logic ack_double;
    } t_item;

    typedef struct packed {
        t_event              event_code;
        logic                press_in_progress;
        logic [TICK_W-1:0]   long_held_ticks;
    } t_result;

endpackage

`default_nettype wire

>>> src/bcc_in_if.sv
// Input channel of the button click classifier: one tick item per transfer.
// Depends on nothing.
`default_nettype none

interface bcc_in_if;
    logic valid;
    logic ready;
    logic button_low;
    logic ack_click;
    logic ack_double;

    modport source (output valid, output button_low, output ack_click,
                    output ack_double, input ready);
    modport sink (input valid, input button_low, input ack_click,
                  input ack_double, output ready);
endinterface

`default_nettype wire

>>> src/bcc_out_if.sv
// Result channel of the button click classifier: one result per transfer.
// Depends on nothing.
`default_nettype none

interface bcc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_code;
    logic        press_in_progress;
    logic [31:0] long_held_ticks;

    modport source (output valid, output event_code, output press_in_progress,
                    output long_held_ticks, input ready);
    modport sink (input valid, input event_code, input press_in_progress,
                  input long_held_ticks, output ready);
endinterface

`default_nettype wire

>>> src/bcc_engine.sv
// Classification engine: tick time, press timing state, configuration
// registers and the per-tick next-state logic. Uses bcc_pkg.
`default_nettype none

module bcc_engine (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bcc_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                             i_step,
    input  wire bcc_pkg::t_item                   i_item,
    output bcc_pkg::t_result                      o_result
);
    import bcc_pkg::*;

    logic [CFG_W-1:0]  r_long_press;
    logic [CFG_W-1:0]  r_double_click;
    logic [TICK_W-1:0] r_now,         n_now;
    logic [TICK_W-1:0] r_press_start, n_press_start;
    logic [TICK_W-1:0] r_last_click,  n_last_click;
    logic [TICK_W-1:0] r_long_start,  n_long_start;
    t_event            r_state,       n_state;
    logic              r_pressing,    n_pressing;
    logic              r_click_valid, n_click_valid;

    t_event            acked_state;
    logic [TICK_W-1:0] tick;
    logic [TICK_W-1:0] press_from;
    logic [TICK_W-1:0] press_age;
    logic [TICK_W-1:0] click_age;
    logic              became_long;

    always_comb begin
        acked_state = r_state;
        if (i_item.ack_click && (acked_state == EV_CLICK)) begin
            acked_state = EV_IDLE;
        end
        if (i_item.ack_double && (acked_state == EV_DOUBLE)) begin
            acked_state = EV_IDLE;
        end

        tick       = r_now + TICK_W'(1);
        press_from = r_pressing ? r_press_start : tick;
        press_age  = tick - press_from;
        click_age  = tick - r_last_click;

        n_now         = tick;
        n_state       = acked_state;
        n_pressing    = r_pressing;
        n_press_start = r_press_start;
        n_last_click  = r_last_click;
        n_long_start  = r_long_start;
        n_click_valid = r_click_valid;
        became_long   = 1'b0;

        if (i_item.button_low) begin
            if (acked_state != EV_LONG) begin
                n_pressing    = 1'b1;
                n_press_start = press_from;
                if (press_age > {{(TICK_W-CFG_W){1'b0}}, r_long_press}) begin
                    n_state      = EV_LONG;
                    n_long_start = press_from;
                    n_pressing   = 1'b0;
                    became_long  = 1'b1;
                end
            end
        end else if (acked_state == EV_LONG) begin
            n_state = EV_IDLE;
        end else if (r_pressing) begin
            n_pressing = 1'b0;
            if (r_click_valid &&
                (click_age < {{(TICK_W-CFG_W){1'b0}}, r_double_click})) begin
                n_state       = EV_DOUBLE;
                n_last_click  = '0;
                n_click_valid = 1'b0;
            end else begin
                n_state       = EV_CLICK;
                n_last_click  = tick;
                n_click_valid = 1'b1;
            end
        end
    end

    always_comb begin
        o_result.event_code        = n_state;
        o_result.press_in_progress = n_pressing;
        if (n_state != EV_LONG) begin
            o_result.long_held_ticks = '0;
        end else if (became_long) begin
            o_result.long_held_ticks = press_age;
        end else begin
            o_result.long_held_ticks = tick - r_long_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press   <= LONG_PRESS_RST;
            r_double_click <= DOUBLE_CLICK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LONG_PRESS: begin
                    r_long_press <= i_cfg_data;
                end
                CFG_DOUBLE_CLICK: begin
                    r_double_click <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now         <= '0;
            r_press_start <= '0;
            r_last_click  <= '0;
            r_long_start  <= '0;
            r_state       <= EV_IDLE;
            r_pressing    <= 1'b0;
            r_click_valid <= 1'b0;
        end else if (i_step) begin
            r_now         <= n_now;
            r_press_start <= n_press_start;
            r_last_click  <= n_last_click;
            r_long_start  <= n_long_start;
            r_state       <= n_state;
            r_pressing    <= n_pressing;
            r_click_valid <= n_click_valid;
        end
    end

endmodule

`default_nettype wire

>>> src/button_click_classifier.sv
// Button click classifier top level: input register, classification engine
// and result register. Uses bcc_pkg, bcc_in_if, bcc_out_if and bcc_engine.
// A tick passes through the input register and then the result register; back-pressure can hold it in either.
// Throughput: one tick item per cycle while the result consumer does not stall.
// Reset (synchronous, active low) clears all timing state, empties both
// registers and loads the thresholds with 1000 and 300 ticks.
`default_nettype none

module button_click_classifier (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bcc_pkg::CFG_W-1:0]        i_cfg_data,
    bcc_in_if.sink                                i_item,
    bcc_out_if.source                             o_result
);
    import bcc_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_res;
    t_result step_res;
    logic    advance;

    assign advance      = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_in_valid || advance;

    bcc_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (r_in_valid && advance),
        .i_item     (r_in_item),
        .o_result   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_item.button_low <= i_item.button_low;
            r_in_item.ack_click  <= i_item.ack_click;
            r_in_item.ack_double <= i_item.ack_double;
        end
        if (r_in_valid && advance) begin
            r_res <= step_res;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.event_code        = r_res.event_code;
    assign o_result.press_in_progress = r_res.press_in_progress;
    assign o_result.long_held_ticks   = r_res.long_held_ticks;

endmodule

`default_nettype wire

>>> verif/button_click_classifier_tb.sv
`timescale 1ns / 100ps
// Testbench for button_click_classifier: feeds tick transfers with random gaps and
// back-pressure, classifies every tick in a local model and checks each result.
// Depends on bcc_pkg, bcc_in_if, bcc_out_if and the button_click_classifier RTL.

module button_click_classifier_tb;
    import bcc_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bcc_in_if  tick_ch ();
    bcc_out_if class_ch ();

    button_click_classifier u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (tick_ch),
        .o_result   (class_ch)
    );

    // Local copy of the classifier state and thresholds.
    logic [CFG_W-1:0]  long_thr;
    logic [CFG_W-1:0]  dbl_thr;
    logic [TICK_W-1:0] now_q;
    logic [TICK_W-1:0] press_start_q;
    logic [TICK_W-1:0] last_click_q;
    logic [TICK_W-1:0] long_start_q;
    t_event            ev_q;
    logic              pressing_q;
    logic              click_valid_q;

    t_item   tick_q[$];
    t_result classified_q[$];
    t_item   next_tick;
    t_item   seen_tick;
    t_result want;

    logic        tick_taken = 1'b0;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned n_ticks_queued;
    int unsigned n_ticks_taken;
    int unsigned n_results;
    int unsigned n_errors;
    int unsigned n_settings;
    int unsigned n_clicks;
    int unsigned n_doubles;
    int unsigned n_longs;
    int unsigned idle_cycles;

    task automatic classify_tick(input t_item it, output t_result res);
        logic [TICK_W-1:0] held;
        logic [TICK_W-1:0] since_click;
        if (it.ack_click && ev_q == EV_CLICK) begin
            ev_q = EV_IDLE;
        end
        if (it.ack_double && ev_q == EV_DOUBLE) begin
            ev_q = EV_IDLE;
        end
        now_q = now_q + 1;
        if (it.button_low) begin
            if (ev_q != EV_LONG) begin
                if (!pressing_q) begin
                    pressing_q    = 1'b1;
                    press_start_q = now_q;
                end
                held = now_q - press_start_q;
                if (held > {16'd0, long_thr}) begin
                    ev_q         = EV_LONG;
                    long_start_q = press_start_q;
                    pressing_q   = 1'b0;
                    n_longs++;
                end
            end
        end else if (ev_q == EV_LONG) begin
            ev_q = EV_IDLE;
        end else if (pressing_q) begin
            pressing_q  = 1'b0;
            since_click = now_q - last_click_q;
            if (click_valid_q && since_click < {16'd0, dbl_thr}) begin
                ev_q          = EV_DOUBLE;
                last_click_q  = '0;
                click_valid_q = 1'b0;
                n_doubles++;
            end else begin
                ev_q          = EV_CLICK;
                last_click_q  = now_q;
                click_valid_q = 1'b1;
                n_clicks++;
            end
        end
        res.event_code        = ev_q;
        res.press_in_progress = pressing_q;
        res.long_held_ticks   = (ev_q == EV_LONG) ? now_q - long_start_q : '0;
    endtask

    task automatic push_tick(input logic down, input logic ack_c, input logic ack_d);
        tick_q.push_back('{button_low: down, ack_click: ack_c, ack_double: ack_d});
        n_ticks_queued++;
    endtask

    function automatic logic rare_ack();
        return $urandom_range(5, 0) == 0;
    endfunction

    // Blocks until every queued tick has been taken and every result has come back.
    task automatic settle();
        while (n_ticks_taken != n_ticks_queued || classified_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LONG_PRESS) begin
            long_thr = val;
        end else begin
            dbl_thr = val;
        end
    endtask

    task automatic apply_thresholds(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] dc);
        settle();
        write_reg(CFG_LONG_PRESS, lp);
        write_reg(CFG_DOUBLE_CLICK, dc);
        n_settings++;
    endtask

    // Mostly press and release gestures timed around the current thresholds,
    // with some ticks of random noise in between.
    task automatic add_gestures(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned lp;
        int unsigned dc;
        int unsigned hold;
        int unsigned gap;
        stop_at = n_ticks_queued + n_items;
        lp      = 32'(long_thr);
        dc      = 32'(dbl_thr);
        while (n_ticks_queued < stop_at) begin
            if ($urandom_range(6, 0) == 0) begin
                repeat ($urandom_range(8, 1)) begin
                    push_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                              1'($urandom_range(1, 0)));
                end
            end else begin
                case ($urandom_range(2, 0))
                    0: hold = $urandom_range(4, 1);
                    1: hold = (lp <= 64) ? lp + $urandom_range(3, 1) : $urandom_range(12, 1);
                    default: hold = (lp <= 64) ? $urandom_range(lp + 8, 1)
                                               : $urandom_range(24, 1);
                endcase
                case ($urandom_range(2, 0))
                    0: gap = $urandom_range(3, 1);
                    1: gap = (dc <= 64) ? $urandom_range(dc + 2, 1) : $urandom_range(40, 1);
                    default: gap = $urandom_range(20, 1);
                endcase
                repeat (hold) push_tick(1'b1, rare_ack(), rare_ack());
                repeat (gap) push_tick(1'b0, rare_ack(), rare_ack());
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tick_ch.valid <= 1'b0;
        end else if (!tick_ch.valid || tick_taken) begin
            if (tick_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                next_tick = tick_q.pop_front();
                tick_ch.valid      <= 1'b1;
                tick_ch.button_low <= next_tick.button_low;
                tick_ch.ack_click  <= next_tick.ack_click;
                tick_ch.ack_double <= next_tick.ack_double;
            end else begin
                tick_ch.valid <= 1'b0;
            end
        end
        class_ch.ready <= i_rst_n && ($urandom_range(99, 0) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        tick_taken <= i_rst_n && tick_ch.valid && tick_ch.ready;
        if (!i_rst_n) begin
            now_q         = '0;
            press_start_q = '0;
            last_click_q  = '0;
            long_start_q  = '0;
            ev_q          = EV_IDLE;
            pressing_q    = 1'b0;
            click_valid_q = 1'b0;
            idle_cycles   = 0;
        end else begin
            if (class_ch.valid && class_ch.ready) begin
                n_results++;
                if (classified_q.size() == 0) begin
                    $display("%0t: result with no tick pending: event %0d, press %0b, held %0d",
                             $time, class_ch.event_code, class_ch.press_in_progress,
                             class_ch.long_held_ticks);
                    n_errors++;
                end else begin
                    want = classified_q.pop_front();
                    if (class_ch.event_code !== want.event_code) begin
                        $display("%0t: event_code expected %0d, actual %0d",
                                 $time, want.event_code, class_ch.event_code);
                        n_errors++;
                    end
                    if (class_ch.press_in_progress !== want.press_in_progress) begin
                        $display("%0t: press_in_progress expected %0b, actual %0b",
                                 $time, want.press_in_progress, class_ch.press_in_progress);
                        n_errors++;
                    end
                    if (class_ch.long_held_ticks !== want.long_held_ticks) begin
                        $display("%0t: long_held_ticks expected %0d, actual %0d",
                                 $time, want.long_held_ticks, class_ch.long_held_ticks);
                        n_errors++;
                    end
                end
            end
            if (tick_ch.valid && tick_ch.ready) begin
                seen_tick.button_low = tick_ch.button_low;
                seen_tick.ack_click  = tick_ch.ack_click;
                seen_tick.ack_double = tick_ch.ack_double;
                classify_tick(seen_tick, want);
                classified_q.push_back(want);
                n_ticks_taken++;
            end
            if ((tick_ch.valid && tick_ch.ready) || (class_ch.valid && class_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, classified_q.size());
                $display("** button_click_classifier: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.button_low = 1'b0;
        tick_ch.ack_click  = 1'b0;
        tick_ch.ack_double = 1'b0;
        class_ch.ready     = 1'b0;
        long_thr           = LONG_PRESS_RST;
        dbl_thr            = DOUBLE_CLICK_RST;
        src_idle_pct       = 26;
        snk_idle_pct       = 80;
        n_ticks_queued     = 0;
        n_ticks_taken      = 0;
        n_results          = 0;
        n_errors           = 0;
        n_settings         = 0;
        n_clicks           = 0;
        n_doubles          = 0;
        n_longs            = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: clicks, a double click, a pending event during a new press,
        // a long press with ignored pressed ticks, and acknowledges that miss.
        apply_thresholds(16'd3, 16'd6);
        push_tick(1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b0, 1'b1, 1'b0);
        repeat (6) push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b1);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1);

        // Zero thresholds: a press goes long on its second tick, no double clicks.
        apply_thresholds(16'd0, 16'd0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);

        apply_thresholds(LONG_PRESS_RST, DOUBLE_CLICK_RST);
        add_gestures(250);

        settle();
        src_idle_pct = 80;
        snk_idle_pct = 26;
        apply_thresholds(16'd1, 16'd1);
        add_gestures(200);
        apply_thresholds(16'hFFFF, 16'hFFFF);
        add_gestures(200);

        settle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (4) begin
            apply_thresholds(CFG_W'($urandom_range(40, 0)), CFG_W'($urandom_range(60, 0)));
            add_gestures(200);
        end

        settle();
        repeat (8) @(negedge i_clk);
        $display("Covered %0d tick transfers and %0d checked results over %0d threshold pairs.",
                 n_ticks_taken, n_results, n_settings);
        $display("Predicted %0d clicks, %0d double clicks and %0d long presses.",
                 n_clicks, n_doubles, n_longs);
        if (n_errors == 0) begin
            $display("** button_click_classifier: PASSED **");
        end else begin
            $display("** button_click_classifier: FAILED **");
        end
        $finish;
    end

endmodule
